FILE: rtl/sa128_pkg.sv
// sa128_pkg: types, command codes and constants for the 128-bit alu
// depends on nothing
`default_nettype none
package sa128_pkg;

    localparam int W = 128;

    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_SUB = 4'd1;
    localparam logic [3:0] CMD_MUL = 4'd2;
    localparam logic [3:0] CMD_DIV = 4'd3;
    localparam logic [3:0] CMD_AND = 4'd4;
    localparam logic [3:0] CMD_OR  = 4'd5;
    localparam logic [3:0] CMD_XOR = 4'd6;
    localparam logic [3:0] CMD_NOT = 4'd7;
    localparam logic [3:0] CMD_SHL = 4'd8;
    localparam logic [3:0] CMD_SHR = 4'd9;
    localparam logic [3:0] CMD_ROL = 4'd10;
    localparam logic [3:0] CMD_ROR = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MUL  = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

    typedef struct packed {
        logic           vld;
        logic [1:0]     mode;
        logic [W-1:0]   n;
        logic [W-1:0]   acc;
        logic [W-1:0]   y;
        logic           ovf;
        logic           neg;
        logic [W-1:0]   res;
        logic [1:0]     status;
        logic           lt;
        logic           eq;
    } cell_t;

endpackage
`default_nettype wire

FILE: rtl/sa128_front.sv
// sa128_front: decodes an item, computes the add, sub, logic, shift and rotate results and sets up the cell chain
// depends on sa128_pkg
`default_nettype none
module sa128_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_vld,
    input  wire logic [3:0]            command,
    input  wire logic [127:0]          a,
    input  wire logic [127:0]          b,
    input  wire logic [7:0]            shift_amount,
    output sa128_pkg::cell_t           st_reg
);

    sa128_pkg::cell_t st_next;
    logic         na;
    logic         nb;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] y;
    logic [127:0] sum;
    logic [6:0]   k;
    logic [255:0] rot;
    logic [6:0]   sn;

    always_comb
    begin
        na  = a[127];
        nb  = b[127];
        ma  = na ? (~a + 128'd1) : a;
        mb  = nb ? (~b + 128'd1) : b;
        y   = (command == sa128_pkg::CMD_ADD) ? b : ~b;
        sum = a + y + {127'd0, command != sa128_pkg::CMD_ADD};
        k   = (command == sa128_pkg::CMD_ROR) ? (7'd0 - shift_amount[6:0]) : shift_amount[6:0];
        rot = {a, a} << k;
        sn  = shift_amount[7] ? 7'd127 : shift_amount[6:0];

        st_next        = '0;
        st_next.vld    = in_vld;
        st_next.n      = ma;
        st_next.y      = mb;
        st_next.neg    = na ^ nb;
        st_next.eq     = (a == b);
        st_next.lt     = (na != nb) ? na : (a < b);
        case (command)
            sa128_pkg::CMD_ADD, sa128_pkg::CMD_SUB:
            begin
                if ((na == y[127]) && (sum[127] != na))
                    st_next.status = sa128_pkg::ST_OVF;
                else
                    st_next.res = sum;
            end
            sa128_pkg::CMD_MUL: st_next.mode = sa128_pkg::MODE_MUL;
            sa128_pkg::CMD_DIV:
            begin
                if (b == 128'd0)
                    st_next.status = sa128_pkg::ST_DIV0;
                else
                    st_next.mode = sa128_pkg::MODE_DIV;
            end
            sa128_pkg::CMD_AND: st_next.res = a & b;
            sa128_pkg::CMD_OR:  st_next.res = a | b;
            sa128_pkg::CMD_XOR: st_next.res = a ^ b;
            sa128_pkg::CMD_NOT: st_next.res = ~a;
            sa128_pkg::CMD_SHL: st_next.res = shift_amount[7] ? 128'd0 : (a << shift_amount[6:0]);
            sa128_pkg::CMD_SHR: st_next.res = $unsigned($signed(a) >>> sn);
            sa128_pkg::CMD_ROL, sa128_pkg::CMD_ROR: st_next.res = rot[255:128];
            default: st_next.res = 128'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (adv)
            st_reg <= st_next;
    end

endmodule
`default_nettype wire

FILE: rtl/sa128_cell.sv
// sa128_cell: one step of shift-add multiply or restoring divide, one operand bit per cell
// depends on sa128_pkg
`default_nettype none
module sa128_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire sa128_pkg::cell_t st_in,
    output sa128_pkg::cell_t      st_reg
);

    sa128_pkg::cell_t st_next;
    logic [129:0] msum;
    logic [128:0] r2;
    logic         qbit;

    always_comb
    begin
        msum    = {1'b0, st_in.acc, 1'b0} + (st_in.n[127] ? {2'b00, st_in.y} : 130'd0);
        r2      = {st_in.acc, st_in.n[127]};
        qbit    = (r2 >= {1'b0, st_in.y});
        st_next = st_in;
        case (st_in.mode)
            sa128_pkg::MODE_MUL:
            begin
                st_next.acc = msum[127:0];
                st_next.ovf = st_in.ovf | msum[129] | msum[128];
                st_next.n   = {st_in.n[126:0], 1'b0};
            end
            sa128_pkg::MODE_DIV:
            begin
                st_next.acc = qbit ? (r2[127:0] - st_in.y) : r2[127:0];
                st_next.n   = {st_in.n[126:0], qbit};
            end
            default: st_next = st_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (adv)
            st_reg <= st_next;
    end

endmodule
`default_nettype wire

FILE: rtl/sa128_back.sv
// sa128_back: signs the multiply or divide magnitude and holds the output item
// depends on sa128_pkg
`default_nettype none
module sa128_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire sa128_pkg::cell_t st_in,
    output logic                  vld_reg,
    output logic [135:0]          data_reg
);

    logic [127:0] mag;
    logic [127:0] res;
    logic [1:0]   status;
    logic         fail;

    always_comb
    begin
        mag    = (st_in.mode == sa128_pkg::MODE_MUL) ? st_in.acc : st_in.n;
        res    = st_in.res;
        status = st_in.status;
        if (st_in.mode != sa128_pkg::MODE_PASS)
        begin
            fail = ((st_in.mode == sa128_pkg::MODE_MUL) && st_in.ovf) ||
                   (st_in.neg ? (mag > {1'b1, 127'd0}) : mag[127]);
            if (fail)
            begin
                res    = 128'd0;
                status = sa128_pkg::ST_OVF;
            end
            else
                res = st_in.neg ? (~mag + 128'd1) : mag;
        end
        else
            fail = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= st_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= {4'd0, st_in.eq, st_in.lt, status, res[63:0], res[127:64]};
    end

endmodule
`default_nettype wire

FILE: rtl/signed_128bit_alu_core.sv
// signed_128bit_alu_core: top level of the 128-bit signed alu
// depends on sa128_pkg, sa128_front, sa128_cell, sa128_back
//
//   channel  | dir | payload
//   s_axis   | in  | command, a_high, a_low, b_high, b_low, shift_amount
//   m_axis   | out | result_high, result_low, status, a_less_than_b, a_equal_b
//
// one item per cycle while the output is not stalled; each item passes the front stage,
// a chain of 128 multiply/divide cells (one operand bit each) and the output register
// reset empties the chain; a stalled output freezes the whole chain
`default_nettype none
module signed_128bit_alu_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [271:0]  s_tdata,  // command, a_high, a_low, b_high, b_low, shift_amount
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [135:0]       m_tdata   // result_high, result_low, status, a_less_than_b, a_equal_b
);

    sa128_pkg::cell_t st [0:128];
    logic adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    sa128_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_vld       (s_tvalid),
        .command      (s_tdata[3:0]),
        .a            ({s_tdata[67:4], s_tdata[131:68]}),
        .b            ({s_tdata[195:132], s_tdata[259:196]}),
        .shift_amount (s_tdata[267:260]),
        .st_reg       (st[0])
    );

    for (genvar i = 0; i < 128; i++)
    begin : g_cell
        sa128_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .st_in  (st[i]),
            .st_reg (st[i+1])
        );
    end

    sa128_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .st_in    (st[128]),
        .vld_reg  (m_tvalid),
        .data_reg (m_tdata)
    );

endmodule
`default_nettype wire

FILE: tb/alu_scoreboard.sv
// alu_scoreboard: watches both streams of the 128-bit alu, predicts every result
// depends on sa128_pkg for command and status codes
`timescale 1ns / 1ps
module alu_scoreboard (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [271:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,
    output int                errors,
    output int                pending,
    output int                checked
);

    typedef struct packed {
        logic [127:0] value;
        logic [1:0]   status;
        logic         lt;
        logic         eq;
    } alu_result_t;

    // predicted results in order, indexed by running counts
    alu_result_t due_mem [0:255];
    int          wr_cnt;
    int          rd_cnt;

    function automatic alu_result_t compute_alu(input logic [3:0] cmd, input logic [127:0] a,
                                                input logic [127:0] b, input logic [7:0] sh);
        alu_result_t r;
        logic [127:0] s;
        logic [127:0] min_val;
        logic signed [255:0] ax;
        logic signed [255:0] bx;
        logic signed [255:0] p;
        int k;
        r.value = '0;
        r.status = sa128_pkg::ST_OK;
        min_val = {1'b1, 127'd0};
        case (cmd)
            sa128_pkg::CMD_ADD: begin
                s = a + b;
                if (a[127] == b[127] && s[127] != a[127]) r.status = sa128_pkg::ST_OVF;
                else r.value = s;
            end
            sa128_pkg::CMD_SUB: begin
                s = a - b;
                if (a[127] != b[127] && s[127] != a[127]) r.status = sa128_pkg::ST_OVF;
                else r.value = s;
            end
            sa128_pkg::CMD_MUL: begin
                ax = {{128{a[127]}}, a};
                bx = {{128{b[127]}}, b};
                p = ax * bx;
                if (p[255:127] != {129{1'b0}} && p[255:127] != {129{1'b1}})
                    r.status = sa128_pkg::ST_OVF;
                else r.value = p[127:0];
            end
            sa128_pkg::CMD_DIV: begin
                if (b == '0) r.status = sa128_pkg::ST_DIV0;
                else if (a == min_val && b == '1) r.status = sa128_pkg::ST_OVF;
                else r.value = $signed(a) / $signed(b);
            end
            sa128_pkg::CMD_AND: r.value = a & b;
            sa128_pkg::CMD_OR:  r.value = a | b;
            sa128_pkg::CMD_XOR: r.value = a ^ b;
            sa128_pkg::CMD_NOT: r.value = ~a;
            sa128_pkg::CMD_SHL: r.value = (sh >= 8'd128) ? '0 : (a << sh);
            sa128_pkg::CMD_SHR: r.value = $signed(a) >>> ((sh > 8'd127) ? 8'd127 : sh);
            sa128_pkg::CMD_ROL, sa128_pkg::CMD_ROR: begin
                k = sh & 8'd127;
                if (cmd == sa128_pkg::CMD_ROR) k = (128 - k) & 127;
                r.value = (k == 0) ? a : ((a << k) | (a >> (128 - k)));
            end
            default: r.value = '0;
        endcase
        r.lt = $signed(a) < $signed(b);
        r.eq = (a == b);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alu_result_t want;
        alu_result_t got;
        if (!rst_n) begin
            errors <= 0;
            checked <= 0;
            wr_cnt <= 0;
            rd_cnt <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_mem[wr_cnt[7:0]] <= compute_alu(s_tdata[3:0],
                                                    {s_tdata[67:4], s_tdata[131:68]},
                                                    {s_tdata[195:132], s_tdata[259:196]},
                                                    s_tdata[267:260]);
                wr_cnt <= wr_cnt + 1;
            end
            if (m_tvalid && m_tready) begin
                got.value = {m_tdata[63:0], m_tdata[127:64]};
                got.status = m_tdata[129:128];
                got.lt = m_tdata[130];
                got.eq = m_tdata[131];
                checked <= checked + 1;
                if (wr_cnt == rd_cnt) begin
                    if (errors < 10) $display("unexpected item from alu: %h", m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = due_mem[rd_cnt[7:0]];
                    rd_cnt <= rd_cnt + 1;
                    if (want !== got) begin
                        if (errors < 10)
                            $display({"mismatch %0d: exp value %h st %0d lt %b eq %b, ",
                                      "got value %h st %0d lt %b eq %b"},
                                     checked, want.value, want.status, want.lt, want.eq,
                                     got.value, got.status, got.lt, got.eq);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = wr_cnt - rd_cnt;

endmodule

FILE: tb/testbench.sv
// testbench: stimulus and verdict for the 128-bit signed alu core
// depends on sa128_pkg, signed_128bit_alu_core and alu_scoreboard
`timescale 1ns / 1ps
module testbench;

    localparam logic [3:0] CMD_SPARE_LO = 4'd12;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 750;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    int           errors;
    int           pending;
    int           checked;
    int           sent;
    int           idle_cycles;
    int           stall_mode;
    int           mode_cycles;

    localparam logic [127:0] MIN_V = {1'b1, 127'd0};
    localparam logic [127:0] MAX_V = {1'b0, {127{1'b1}}};
    localparam logic [127:0] ONES  = '1;

    signed_128bit_alu_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    alu_scoreboard u_score (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one item, valid stays high until accepted
    task automatic send_item(input logic [3:0] cmd, input logic [127:0] a,
                             input logic [127:0] b, input logic [7:0] sh);
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, sh, b[63:0], b[127:64], a[63:0], a[127:64], cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [127:0] pick_operand();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(9, 0))
            0: v = MIN_V;
            1: v = MAX_V;
            2: v = ONES;
            3: v = '0;
            4: v = {{64{v[127]}}, v[63:0]};
            5: v = {{100{v[127]}}, v[27:0]};
            6: v = 128'd1 << $urandom_range(127, 0);
            7: v = {{72{v[127]}}, v[55:0]};
            default: ;
        endcase
        return v;
    endfunction

    // receiver stall pattern, switched periodically to a randomly chosen mode
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            mode_cycles <= 0;
        end else begin
            if (mode_cycles == 300) begin
                mode_cycles <= 0;
                stall_mode <= $urandom_range(2, 0);
            end else begin
                mode_cycles <= mode_cycles + 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(9, 0) < 7);
                default: m_tready <= ($urandom_range(15, 0) == 0) ? ~m_tready : m_tready;
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int burst;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(sa128_pkg::CMD_ADD, MAX_V, 128'd1, 8'd0);
        send_item(sa128_pkg::CMD_ADD, MIN_V, ONES, 8'd255);
        send_item(sa128_pkg::CMD_ADD, 128'd5, ONES, 8'd0);
        send_item(sa128_pkg::CMD_SUB, '0, MIN_V, 8'd0);
        send_item(sa128_pkg::CMD_SUB, ONES, MIN_V, 8'd0);
        send_item(sa128_pkg::CMD_MUL, MAX_V, 128'd2, 8'd0);
        send_item(sa128_pkg::CMD_MUL, {64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000},
                  {64'd1, 64'd0}, 8'd0);
        send_item(sa128_pkg::CMD_MUL, MIN_V, ONES, 8'd0);
        send_item(sa128_pkg::CMD_MUL, ONES, ONES, 8'd0);
        send_item(sa128_pkg::CMD_DIV, MAX_V, '0, 8'd0);
        send_item(sa128_pkg::CMD_DIV, MIN_V, ONES, 8'd0);
        send_item(sa128_pkg::CMD_DIV, -128'sd7, 128'd2, 8'd0);
        send_item(sa128_pkg::CMD_DIV, MIN_V, MAX_V, 8'd0);
        send_item(sa128_pkg::CMD_AND, ONES, {2{64'h5555_AAAA_0F0F_F0F0}}, 8'd0);
        send_item(sa128_pkg::CMD_OR, MIN_V, 128'd1, 8'd0);
        send_item(sa128_pkg::CMD_XOR, MAX_V, MAX_V, 8'd0);
        send_item(sa128_pkg::CMD_NOT, '0, MIN_V, 8'd0);
        send_item(sa128_pkg::CMD_SHL, ONES, '0, 8'd0);
        send_item(sa128_pkg::CMD_SHL, ONES, '0, 8'd200);
        send_item(sa128_pkg::CMD_SHR, MIN_V, '0, 8'd130);
        send_item(sa128_pkg::CMD_SHR, MAX_V, '0, 8'd127);
        send_item(sa128_pkg::CMD_ROL, {64'h8000_0000_0000_0001, 64'h1}, '0, 8'd129);
        send_item(sa128_pkg::CMD_ROR, MAX_V, '0, 8'd128);
        send_item(CMD_SPARE_LO, ONES, ONES, 8'd255);
        send_item(CMD_SPARE_HI, MIN_V, MAX_V, 8'd1);

        // hold off until the chain has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        while (sent < 25 + RANDOM_ITEMS) begin
            burst = $urandom_range(40, 1);
            repeat (burst) begin
                logic [127:0] a;
                logic [127:0] b;
                logic [3:0] cmd;
                a = pick_operand();
                b = ($urandom_range(9, 0) == 0) ? a : pick_operand();
                cmd = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 12))
                                                   : 4'($urandom_range(11, 0));
                send_item(cmd, a, b, 8'($urandom_range(255, 0)));
            end
            if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(30, 1));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d items over all twelve commands and spare codes, %0d results checked",
                 sent, checked);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/sa128_pkg.sv
rtl/sa128_front.sv
rtl/sa128_cell.sv
rtl/sa128_back.sv
rtl/signed_128bit_alu_core.sv
tb/alu_scoreboard.sv
tb/testbench.sv
